@@ hdl/ddmo_pkg.sv @@
// shared types and constants for the differential drive odometry unit
package ddmo_pkg;

    localparam logic signed [6:0] SpdFull = 7'sd60;
    localparam logic signed [6:0] SpdTurn = 7'sd30;
    localparam logic signed [6:0] SpdArc  = 7'sd36;
    localparam logic signed [6:0] SpdSlow = 7'sd15;
    localparam logic signed [6:0] SpdBack = -7'sd6;

    localparam logic signed [21:0] DsGain  = 22'sd1126999;
    localparam logic signed [19:0] AngGain = 20'sd396831;
    localparam logic signed [33:0] CordicX0 = 34'sd652032874;
    localparam logic [31:0] Quarter = 32'h4000_0000;

    typedef enum logic [3:0] {
        ACT_STOP     = 4'd0,
        ACT_STRAIGHT = 4'd1,
        ACT_CSETUP   = 4'd2,
        ACT_ARC      = 4'd3,
        ACT_SQ_LEG   = 4'd4,
        ACT_SQ_TURN  = 4'd5,
        ACT_LN_FWD   = 4'd6,
        ACT_LN_LEFT  = 4'd7,
        ACT_LN_RIGHT = 4'd8,
        ACT_LN_SRCH  = 4'd9
    } t_action;

    typedef enum logic [1:0] {
        MOTION_FWD = 2'd0,
        MOTION_SQR = 2'd1,
        MOTION_ARC = 2'd2,
        MOTION_TRK = 2'd3
    } t_mode;

    localparam logic [2:0] RegMode   = 3'd0;
    localparam logic [2:0] RegLine   = 3'd1;
    localparam logic [2:0] RegGoal   = 3'd2;
    localparam logic [2:0] RegStr    = 3'd3;
    localparam logic [2:0] RegCSetup = 3'd4;
    localparam logic [2:0] RegCRun   = 3'd5;
    localparam logic [2:0] RegSide   = 3'd6;

    // control handed from the top level to the cordic unit
    typedef struct packed {
        logic        start;
        logic [31:0] angle;
    } t_cordic_req;

    typedef struct packed {
        logic               done;
        logic signed [33:0] cos_v;
        logic signed [33:0] sin_v;
    } t_cordic_rsp;

    function automatic logic [31:0] atan_lut(input logic [4:0] idx);
        logic [31:0] v;
        case (idx)
            5'd0:  v = 32'd536870912;
            5'd1:  v = 32'd316933406;
            5'd2:  v = 32'd167458907;
            5'd3:  v = 32'd85004756;
            5'd4:  v = 32'd42667331;
            5'd5:  v = 32'd21354465;
            5'd6:  v = 32'd10679838;
            5'd7:  v = 32'd5340245;
            5'd8:  v = 32'd2670163;
            5'd9:  v = 32'd1335087;
            5'd10: v = 32'd667544;
            5'd11: v = 32'd333772;
            5'd12: v = 32'd166886;
            5'd13: v = 32'd83443;
            5'd14: v = 32'd41722;
            5'd15: v = 32'd20861;
            5'd16: v = 32'd10430;
            5'd17: v = 32'd5215;
            5'd18: v = 32'd2608;
            5'd19: v = 32'd1304;
            5'd20: v = 32'd652;
            5'd21: v = 32'd326;
            5'd22: v = 32'd163;
            5'd23: v = 32'd81;
            5'd24: v = 32'd41;
            5'd25: v = 32'd20;
            5'd26: v = 32'd10;
            5'd27: v = 32'd5;
            5'd28: v = 32'd3;
            5'd29: v = 32'd1;
            default: v = 32'd0;
        endcase
        return v;
    endfunction

endpackage

@@ hdl/ddmo_cordic.sv @@
// iterative cordic sine and cosine, one micro-rotation per cycle
module ddmo_cordic
    import ddmo_pkg::*;
#(
    parameter int unsigned STEPS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cordic_req i_req,
    output t_cordic_rsp o_rsp
);
    logic               r_busy;
    logic [4:0]         r_idx;
    logic [1:0]         r_quad;
    logic signed [33:0] r_x, r_y;
    logic signed [32:0] r_z;
    logic               r_done;

    logic [1:0]         quad;
    logic [31:0]        resid;
    logic signed [33:0] xs, ys;
    logic signed [32:0] at;

    assign quad  = 2'((i_req.angle + 32'h2000_0000) >> 30);
    assign resid = i_req.angle - {quad, 30'd0};
    assign xs    = r_x >>> r_idx;
    assign ys    = r_y >>> r_idx;
    assign at    = $signed({1'b0, atan_lut(r_idx)});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_idx  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_idx  <= '0;
                r_quad <= quad;
                r_x    <= CordicX0;
                r_y    <= '0;
                r_z    <= $signed({resid[31], resid});
            end else if (r_busy) begin
                if (!r_z[32]) begin
                    r_x <= r_x - ys;
                    r_y <= r_y + xs;
                    r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys;
                    r_y <= r_y - xs;
                    r_z <= r_z + at;
                end
                if (r_idx == 5'(STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_idx <= r_idx + 5'd1;
                end
            end
        end
    end

    always_comb begin
        o_rsp.done = r_done;
        case (r_quad)
            2'd0: begin o_rsp.cos_v = r_x;  o_rsp.sin_v = r_y;  end
            2'd1: begin o_rsp.cos_v = -r_y; o_rsp.sin_v = r_x;  end
            2'd2: begin o_rsp.cos_v = -r_x; o_rsp.sin_v = -r_y; end
            default: begin o_rsp.cos_v = r_y; o_rsp.sin_v = -r_x; end
        endcase
    end
endmodule

@@ hdl/diff_drive_motion_odometry_unit.sv @@
// top level of the differential drive motion sequencer with odometry
// One control tick in, one result out. A tick that moves the robot passes
// through speed selection, which also loads the cordic, then the iterative
// cordic and its registered done flag, then ST_MULX and ST_MULY, in which one
// shared 34x29 multiplier forms the x and then the y step, and ST_OUT to latch
// the result. A tick that stops or follows a stop skips the cordic and goes
// from speed selection straight to ST_OUT. The input is not ready while a tick
// is in work or its result waits to be taken, so the unit takes no new tick
// before the last result has been taken.
// Registers sit on the APB port at byte address 4*i in the documented order.
module diff_drive_motion_odometry_unit
    import ddmo_pkg::*;
#(
    parameter int unsigned CORDIC_STEPS = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [9:0]        i_left_ground,
    input  logic [9:0]        i_center_ground,
    input  logic [9:0]        i_right_ground,
    output logic              o_valid,
    input  logic              i_ready,
    output logic signed [6:0] o_left_speed_cmd,
    output logic signed [6:0] o_right_speed_cmd,
    output logic signed [31:0] o_pose_x,
    output logic signed [31:0] o_pose_y,
    output logic [31:0]       o_heading,
    output logic [3:0]        o_action,
    output logic              o_finished,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [4:0]        paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);
    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_SEL  = 6'b000010,
        ST_ROT  = 6'b000100,
        ST_MULX = 6'b001000,
        ST_MULY = 6'b010000,
        ST_OUT  = 6'b100000
    } t_state;

    t_state r_state;

    // configuration
    logic [1:0]  r_mode;
    logic [9:0]  r_line_th, r_goal_th;
    logic [15:0] r_str, r_csetup, r_crun, r_side;

    // tracked state
    logic signed [31:0] r_px, r_py;
    logic [31:0] r_theta, r_turn_start;
    logic [15:0] r_elapsed, r_leg;
    logic        r_cphase, r_sphase, r_armed, r_stopped;
    logic [2:0]  r_sides;

    // tick in work
    logic [9:0]  r_lg, r_cg, r_rg;
    logic signed [6:0] r_sl, r_sr;
    logic [3:0]  r_act;
    logic signed [28:0] r_ds;
    logic [31:0] r_dth;
    logic signed [33:0] r_cos, r_sin;
    logic signed [63:0] r_prod;

    t_cordic_req cq;
    t_cordic_rsp cr;

    ddmo_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(cq), .o_rsp(cr)
    );

    assign pready  = 1'b1;
    assign o_ready = (r_state == ST_IDLE) && !o_valid;

    // apb write and readback
    logic wr;
    logic [2:0] ra;
    assign wr = psel && penable && pwrite;
    assign ra = paddr[4:2];

    always_comb begin
        case (ra)
            RegMode:   prdata = {30'd0, r_mode};
            RegLine:   prdata = {22'd0, r_line_th};
            RegGoal:   prdata = {22'd0, r_goal_th};
            RegStr:    prdata = {16'd0, r_str};
            RegCSetup: prdata = {16'd0, r_csetup};
            RegCRun:   prdata = {16'd0, r_crun};
            RegSide:   prdata = {16'd0, r_side};
            default:   prdata = '0;
        endcase
    end

    // speed and phase selection, on a captured tick
    logic signed [6:0] n_sl, n_sr;
    logic [3:0]  n_act;
    logic        n_stop, n_cphase, n_sphase, n_armed;
    logic [15:0] n_elapsed, n_leg;
    logic [2:0]  n_sides;
    logic [31:0] n_turn_start, d;

    always_comb begin
        n_sl = SpdFull; n_sr = SpdFull; n_act = ACT_STOP; n_stop = 1'b0;
        n_cphase = r_cphase; n_sphase = r_sphase; n_armed = r_armed;
        n_sides = r_sides; n_turn_start = r_turn_start; n_leg = r_leg;
        n_elapsed = (r_elapsed != 16'hFFFF) ? r_elapsed + 16'd1 : r_elapsed;
        d = '0;
        case (t_mode'(r_mode))
            MOTION_FWD: begin
                n_act = ACT_STRAIGHT;
                if (n_elapsed > r_str) n_stop = 1'b1;
            end
            MOTION_ARC: begin
                if (!r_cphase) begin
                    n_act = ACT_CSETUP;
                    if (n_elapsed > r_csetup) begin
                        n_cphase = 1'b1; n_elapsed = '0;
                    end
                end else begin
                    n_sr = SpdArc; n_act = ACT_ARC;
                    if (n_elapsed > r_crun) n_stop = 1'b1;
                end
            end
            MOTION_SQR: begin
                if (r_sides >= 3'd4) begin
                    n_stop = 1'b1;
                end else if (!r_sphase) begin
                    n_act = ACT_SQ_LEG;
                    if (r_leg != 16'hFFFF) n_leg = r_leg + 16'd1;
                    if (n_leg > r_side) begin
                        n_sphase = 1'b1; n_leg = '0;
                    end
                end else begin
                    if (!r_armed) begin
                        n_turn_start = r_theta; n_armed = 1'b1;
                    end
                    n_sl = SpdTurn; n_sr = -SpdTurn; n_act = ACT_SQ_TURN;
                    d = r_theta - n_turn_start;
                    // magnitude of the wrapped difference reaches a quarter turn
                    if ((!d[31] && d >= Quarter) || (d[31] && d <= (32'd0 - Quarter))) begin
                        n_sphase = 1'b0; n_sides = r_sides + 3'd1;
                        n_leg = '0; n_armed = 1'b0;
                    end
                end
            end
            default: begin
                n_act = ACT_LN_FWD;
                if (r_cg < r_line_th) begin
                    n_act = ACT_LN_FWD;
                end else if (r_lg < r_line_th) begin
                    n_sl = SpdBack; n_sr = SpdSlow; n_act = ACT_LN_LEFT;
                end else if (r_rg < r_line_th) begin
                    n_sl = SpdSlow; n_sr = SpdBack; n_act = ACT_LN_RIGHT;
                end else begin
                    n_sl = SpdTurn; n_sr = -SpdTurn; n_act = ACT_LN_SRCH;
                end
                if (r_lg < r_goal_th && r_cg < r_goal_th && r_rg < r_goal_th)
                    n_stop = 1'b1;
            end
        endcase
    end

    // shared multiplier and rounding of the pose step
    logic signed [33:0] mul_b;
    logic signed [63:0] n_prod;
    logic signed [17:0] step;
    logic signed [32:0] n_pos;
    logic signed [31:0] sat_pos, pos_old;
    logic signed [63:0] rnd;

    assign mul_b  = (r_state == ST_MULX) ? r_cos : r_sin;
    assign n_prod = 64'(r_ds) * 64'(mul_b);
    assign rnd    = r_prod + (64'sd1 <<< 45);
    assign step   = 18'(rnd >>> 46);
    assign pos_old = (r_state == ST_MULY) ? r_px : r_py;
    assign n_pos  = 33'(pos_old) + 33'(step);
    assign sat_pos = (n_pos > 33'sd2147483647) ? 32'sh7FFF_FFFF :
                     (n_pos < -33'sd2147483648) ? 32'sh8000_0000 : 32'(n_pos);

    logic signed [7:0]  sum_s, dif_s;
    logic signed [31:0] dth_n;
    assign sum_s = 8'(n_sl) + 8'(n_sr);
    assign dif_s = 8'(n_sr) - 8'(n_sl);
    assign dth_n = 32'(dif_s) * 32'(AngGain);

    assign cq.start = (r_state == ST_SEL) && !r_stopped && !n_stop;
    assign cq.angle = r_theta + 32'($signed(dth_n) >>> 1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_mode <= MOTION_TRK; r_line_th <= 10'd500; r_goal_th <= 10'd298;
            r_str <= 16'd250; r_csetup <= 16'd156; r_crun <= 16'd468;
            r_side <= 16'd187;
            r_px <= '0; r_py <= '0; r_theta <= Quarter; r_turn_start <= '0;
            r_elapsed <= '0; r_leg <= '0; r_cphase <= 1'b0; r_sphase <= 1'b0;
            r_armed <= 1'b0; r_sides <= '0; r_stopped <= 1'b0;
            o_valid <= 1'b0;
        end else begin
            if (wr) begin
                case (ra)
                    RegMode:   r_mode    <= pwdata[1:0];
                    RegLine:   r_line_th <= pwdata[9:0];
                    RegGoal:   r_goal_th <= pwdata[9:0];
                    RegStr:    r_str     <= pwdata[15:0];
                    RegCSetup: r_csetup  <= pwdata[15:0];
                    RegCRun:   r_crun    <= pwdata[15:0];
                    RegSide:   r_side    <= pwdata[15:0];
                    default: ;
                endcase
            end
            case (r_state)
                ST_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_lg <= i_left_ground; r_cg <= i_center_ground;
                        r_rg <= i_right_ground;
                        r_state <= ST_SEL;
                    end
                end
                ST_SEL: begin
                    if (r_stopped || n_stop) begin
                        // stop tick or frozen run: zero speeds, pose held
                        r_stopped <= 1'b1;
                        if (!r_stopped) begin
                            r_elapsed <= n_elapsed; r_leg <= n_leg;
                            r_cphase <= n_cphase; r_sphase <= n_sphase;
                            r_armed <= n_armed; r_sides <= n_sides;
                            r_turn_start <= n_turn_start;
                        end
                        r_sl <= '0; r_sr <= '0; r_act <= ACT_STOP;
                        r_state <= ST_OUT;
                    end else begin
                        r_elapsed <= n_elapsed; r_leg <= n_leg;
                        r_cphase <= n_cphase; r_sphase <= n_sphase;
                        r_armed <= n_armed; r_sides <= n_sides;
                        r_turn_start <= n_turn_start;
                        r_sl <= n_sl; r_sr <= n_sr; r_act <= n_act;
                        r_ds <= 29'(sum_s) * DsGain;
                        r_dth <= dth_n;
                        r_state <= ST_ROT;
                    end
                end
                ST_ROT: begin
                    if (cr.done) begin
                        r_cos <= cr.cos_v; r_sin <= cr.sin_v;
                        r_state <= ST_MULX;
                    end
                end
                ST_MULX: begin
                    r_prod <= n_prod;
                    r_state <= ST_MULY;
                end
                ST_MULY: begin
                    r_px <= sat_pos;
                    r_prod <= n_prod;
                    r_state <= ST_OUT;
                    r_theta <= r_theta + r_dth;
                end
                ST_OUT: begin
                    if (!r_stopped) r_py <= sat_pos;
                    r_state <= ST_IDLE;
                    o_valid <= 1'b1;
                end
                default: r_state <= ST_IDLE;
            endcase
            if (o_valid && i_ready) o_valid <= 1'b0;
        end
    end

    // result fields read live from the registers, frozen while valid
    assign o_left_speed_cmd  = r_sl;
    assign o_right_speed_cmd = r_sr;
    assign o_pose_x   = r_px;
    assign o_pose_y   = r_py;
    assign o_heading  = r_theta;
    assign o_action   = r_act;
    assign o_finished = r_stopped;

    // no new transaction while a result waits
    a_busy_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_ready) else $error("accept while result pending");
    // a stopped run keeps zero left speed and the stop action
    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_finished) |-> (o_left_speed_cmd == 7'sd0 && o_action == ACT_STOP))
        else $error("stopped run reports motion");
    // once stopped, stays stopped
    a_stop_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stopped |=> r_stopped) else $error("stop released");
endmodule
